/* rtl/htd_pkg.sv */
`default_nettype none

package htd_pkg;

    // field widths
    localparam int IDX_W     = 9;
    localparam int SYM_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 31;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int BIT_CNT_W = 4;

    // default code table size
    localparam int NODE_COUNT_DEF = 512;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // item opcodes
    localparam logic OP_NODE = 1'b0;
    localparam logic OP_CODE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_SYM_LIMIT = 1'b0;

    // one entry of the code tree
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] symbol;
    } htd_node_t;

    // classified item as it travels through the queue
    typedef struct packed {
        logic              is_code;
        logic [IDX_W-1:0]  index;
        htd_node_t         node;
        logic [BYTE_W-1:0] code;
    } htd_item_t;

    // configuration seen by the walker
    typedef struct packed {
        logic             restart;
        logic [LEN_W-1:0] sym_limit;
    } htd_cfg_t;

endpackage

`default_nettype wire

/* rtl/htd_front.sv */
`default_nettype none

module htd_front (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         item_valid,
    output logic                        item_ready,
    input  wire                         op,
    input  wire  [htd_pkg::IDX_W-1:0]   node_index,
    input  wire  [htd_pkg::IDX_W-1:0]   left_index,
    input  wire  [htd_pkg::IDX_W-1:0]   right_index,
    input  wire                         is_leaf,
    input  wire  [htd_pkg::SYM_W-1:0]   leaf_symbol,
    input  wire  [htd_pkg::BYTE_W-1:0]  code_byte,
    output logic                        q_valid,
    input  wire                         q_ready,
    output htd_pkg::htd_item_t          q_item
);
    import htd_pkg::*;

    htd_item_t          q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;
    htd_item_t          item_in;

    // classify the incoming item
    always_comb
    begin
        item_in.is_code     = (op == OP_CODE);
        item_in.index       = node_index;
        item_in.node.left   = left_index;
        item_in.node.right  = right_index;
        item_in.node.leaf   = is_leaf;
        item_in.node.symbol = leaf_symbol;
        item_in.code        = code_byte;
    end

    // queue handshake
    assign item_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_item     = q_mem[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

/* rtl/htd_back.sv */
`default_nettype none

module htd_back #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  htd_pkg::htd_cfg_t           cfg,
    input  wire                         q_valid,
    output logic                        q_ready,
    input  htd_pkg::htd_item_t          q_item,
    output logic                        result_valid,
    input  wire                         result_ready,
    output logic [htd_pkg::SYM_W-1:0]   symbol,
    output logic                        last_of_byte,
    output logic                        text_done
);
    import htd_pkg::*;

    localparam int          AW         = $clog2(NODE_COUNT);
    localparam logic [31:0] NODE_LIMIT = 32'(NODE_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return ({{(32-IDX_W){1'b0}}, idx} < NODE_LIMIT);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+AW-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    // node table
    htd_node_t              node_mem [NODE_COUNT];
    htd_node_t              rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;

    // walk control
    logic [1:0]             state_reg,      state_next;
    logic [BYTE_W-1:0]      byte_reg,       byte_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg,    bit_cnt_next;
    logic                   pend_reg,       pend_next;
    logic                   zero_reg,       zero_next;
    logic [IDX_W-1:0]       pos_reg,        pos_next;
    logic [LEN_W-1:0]       count_reg,      count_next;
    logic                   finished_reg,   finished_next;
    logic [IDX_W-1:0]       root_left_reg,  root_left_next;
    logic [IDX_W-1:0]       root_right_reg, root_right_next;

    // symbol held until the byte shows whether another follows
    logic                   hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0]       hold_sym_reg,   hold_sym_next;
    logic                   hold_done_reg,  hold_done_next;

    // output register
    logic                   out_valid_reg,  out_valid_next;
    logic [SYM_W-1:0]       out_sym_reg,    out_sym_next;
    logic                   out_last_reg,   out_last_next;
    logic                   out_done_reg,   out_done_next;

    htd_node_t              ent;
    logic                   leaf_now;
    logic [IDX_W-1:0]       cur_left;
    logic [IDX_W-1:0]       cur_right;
    logic [IDX_W-1:0]       next_idx;
    logic [LEN_W-1:0]       count_inc;
    logic                   done_now;
    logic                   out_free;
    logic                   stall;
    logic                   bits_left;
    logic                   push;
    logic                   push_last;

    // entry returned by the last table read
    assign ent       = zero_reg ? '0 : rd_data_reg;
    assign leaf_now  = (state_reg == ST_WALK) && pend_reg && ent.leaf;
    assign cur_left  = leaf_now ? root_left_reg  : ent.left;
    assign cur_right = leaf_now ? root_right_reg : ent.right;
    assign next_idx  = byte_reg[BYTE_W-1] ? cur_right : cur_left;
    assign count_inc = count_reg + LEN_W'(1);
    assign done_now  = leaf_now && (count_inc == cfg.sym_limit);
    assign out_free  = !out_valid_reg || result_ready;
    assign stall     = leaf_now && hold_valid_reg && !out_free;
    assign bits_left = (bit_cnt_reg != BIT_CNT_W'(BYTE_W));
    assign wr_addr   = to_addr(q_item.index);

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        pend_next       = pend_reg;
        zero_next       = zero_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        finished_next   = finished_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_done_next  = hold_done_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        q_ready         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = to_addr(next_idx);
        wr_en           = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (!q_item.is_code)
                    begin
                        // node write, root children also kept in flops
                        wr_en = in_range(q_item.index);
                        if (q_item.index == '0)
                        begin
                            root_left_next  = q_item.node.left;
                            root_right_next = q_item.node.right;
                        end
                    end
                    else if (!finished_reg && (count_reg < cfg.sym_limit))
                    begin
                        // fetch the entry at the current walk position
                        byte_next    = q_item.code;
                        bit_cnt_next = '0;
                        pend_next    = 1'b0;
                        rd_en        = in_range(pos_reg);
                        rd_addr      = to_addr(pos_reg);
                        zero_next    = !in_range(pos_reg);
                        state_next   = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    // leaf reached by the previous bit
                    if (leaf_now)
                    begin
                        count_next      = count_inc;
                        pos_next        = '0;
                        hold_valid_next = 1'b1;
                        hold_sym_next   = ent.symbol;
                        hold_done_next  = done_now;
                        push            = hold_valid_reg;
                    end
                    if (done_now)
                    begin
                        finished_next = 1'b1;
                        pend_next     = 1'b0;
                        state_next    = ST_FLUSH;
                    end
                    else if (bits_left)
                    begin
                        // step to the child chosen by the next bit
                        rd_en        = in_range(next_idx);
                        zero_next    = !in_range(next_idx);
                        pos_next     = next_idx;
                        byte_next    = {byte_reg[BYTE_W-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        pend_next    = 1'b1;
                    end
                    else
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                // the held symbol is the last one of this byte
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register
        if (push)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = hold_sym_reg;
            out_last_next  = push_last;
            out_done_next  = hold_done_reg;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end

        // register write starts a new text
        if (cfg.restart)
        begin
            pos_next      = '0;
            count_next    = '0;
            finished_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bit_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            zero_reg       <= 1'b0;
            pos_reg        <= '0;
            count_reg      <= '0;
            finished_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_reg       <= pend_next;
            zero_reg       <= zero_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            finished_reg   <= finished_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        hold_sym_reg   <= hold_sym_next;
        hold_done_reg  <= hold_done_next;
        out_sym_reg    <= out_sym_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    // node table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= q_item.node;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign symbol       = out_sym_reg;
    assign last_of_byte = out_last_reg;
    assign text_done    = out_done_reg;

endmodule

`default_nettype wire

/* rtl/huffman_tree_decoder_unit.sv */
// flow: the walker takes a node write while idle; a code byte is walked as
//   one table fetch, one table read per bit, a final leaf check and a flush
// the walker takes the next item only after the last code byte is flushed;
//   a 4-entry input queue and an output register decouple both sides
// reset: rst_n clears walk position, symbol count, symbol limit and the queues;
//   the node table keeps no reset and must be written before use
`default_nettype none

module huffman_tree_decoder_unit #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [htd_pkg::PADDR_W-1:0]  paddr,
    input  wire  [htd_pkg::DATA_W-1:0]   pwdata,
    output logic [htd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  wire                          item_valid,
    output logic                         item_ready,
    input  wire                          op,
    input  wire  [htd_pkg::IDX_W-1:0]    node_index,
    input  wire  [htd_pkg::IDX_W-1:0]    left_index,
    input  wire  [htd_pkg::IDX_W-1:0]    right_index,
    input  wire                          is_leaf,
    input  wire  [htd_pkg::SYM_W-1:0]    leaf_symbol,
    input  wire  [htd_pkg::BYTE_W-1:0]   code_byte,
    output logic                         result_valid,
    input  wire                          result_ready,
    output logic [htd_pkg::SYM_W-1:0]    symbol,
    output logic                         last_of_byte,
    output logic                         text_done
);
    import htd_pkg::*;

    logic [LEN_W-1:0]  len_reg;
    logic              reg_sel;
    logic              reg_wr;
    htd_cfg_t          cfg;
    logic              q_valid;
    logic              q_ready;
    htd_item_t         q_item;

    // register port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_SYM_LIMIT);
    assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {{(DATA_W-LEN_W){1'b0}}, len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (reg_wr)
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // restart travels with the write transfer
    assign cfg.restart   = reg_wr;
    assign cfg.sym_limit = len_reg;

    htd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .op          (op),
        .node_index  (node_index),
        .left_index  (left_index),
        .right_index (right_index),
        .is_leaf     (is_leaf),
        .leaf_symbol (leaf_symbol),
        .code_byte   (code_byte),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    htd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .symbol       (symbol),
        .last_of_byte (last_of_byte),
        .text_done    (text_done)
    );

endmodule

`default_nettype wire

/* rtl/htd_chk.sv */
`default_nettype none

module htd_chk (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [htd_pkg::PADDR_W-1:0]  paddr,
    input  wire  [htd_pkg::DATA_W-1:0]   pwdata,
    input  wire  [htd_pkg::DATA_W-1:0]   prdata,
    input  wire                          result_valid,
    input  wire                          result_ready,
    input  wire  [htd_pkg::SYM_W-1:0]    symbol,
    input  wire                          last_of_byte,
    input  wire                          text_done
);
    import htd_pkg::*;

    logic len_wr;

    assign len_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_SYM_LIMIT);

    // a stalled result transfer keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(symbol) && $stable(last_of_byte) && $stable(text_done)))
        else $error("result changed while stalled");

    // the completing symbol ends its byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && text_done) |-> last_of_byte)
        else $error("text_done without last_of_byte");

    // nothing is offered right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

    // symbol limit reads back what was written
    a_len_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (len_wr ##1 (paddr[PADDR_W-1:2] == REG_SYM_LIMIT)) |->
            (prdata == {{(DATA_W-LEN_W){1'b0}}, $past(pwdata[LEN_W-1:0])}))
        else $error("symbol limit readback mismatch");

endmodule

bind huffman_tree_decoder_unit htd_chk u_htd_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .symbol       (symbol),
    .last_of_byte (last_of_byte),
    .text_done    (text_done)
);

`default_nettype wire

/* test/tb_huffman_tree_decoder_unit.sv */
`timescale 1ns / 100ps

module tb_huffman_tree_decoder_unit;

    import htd_pkg::*;

    localparam int TARGET_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_REPORTS   = 10;
    localparam int NODES         = NODE_COUNT_DEF;
    localparam logic [PADDR_W-1:0] SYM_LIMIT_ADDR = {REG_SYM_LIMIT, 2'b00};

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;
    typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_ONE } row_check_t;

    // one decoded symbol as it should leave the block
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             done;
    } decoded_t;

    // one row of the directed stimulus
    typedef struct {
        row_kind_t         kind;
        logic              op;
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
        logic              is_leaf;
        logic [SYM_W-1:0]  leaf_symbol;
        logic [BYTE_W-1:0] code_byte;
        logic [DATA_W-1:0] length_word;
        row_check_t        check;
        decoded_t          typed;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                item_valid;
    logic                item_ready;
    logic                op;
    logic [IDX_W-1:0]    node_index;
    logic [IDX_W-1:0]    left_index;
    logic [IDX_W-1:0]    right_index;
    logic                is_leaf;
    logic [SYM_W-1:0]    leaf_symbol;
    logic [BYTE_W-1:0]   code_byte;
    logic                result_valid;
    logic                result_ready;
    logic [SYM_W-1:0]    symbol;
    logic                last_of_byte;
    logic                text_done;

    // predictor state
    htd_node_t           code_tree [NODES];
    bit                  entry_written [NODES];
    logic [IDX_W-1:0]    written_entries [$];
    logic [IDX_W-1:0]    tree_cursor;
    logic [LEN_W-1:0]    symbol_count;
    logic [LEN_W-1:0]    sym_limit;
    bit                  text_finished;

    decoded_t            pending_symbols [$];
    decoded_t            oldest_symbol;
    plan_row_t           directed_plan [$];
    int                  mismatches;
    int                  decoding_items;
    bit                  steady;

    huffman_tree_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .node_index   (node_index),
        .left_index   (left_index),
        .right_index  (right_index),
        .is_leaf      (is_leaf),
        .leaf_symbol  (leaf_symbol),
        .code_byte    (code_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .symbol       (symbol),
        .last_of_byte (last_of_byte),
        .text_done    (text_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // result side stalls
    always @(negedge clk)
    begin
        result_ready <= steady || ($urandom_range(0, 99) >= 19);
    end

    // compare each result transfer with the oldest expected symbol
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready) begin
            if (pending_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected symbol %02h last %0b done %0b",
                             symbol, last_of_byte, text_done);
            end
            else begin
                oldest_symbol = pending_symbols.pop_front();
                if (symbol !== oldest_symbol.sym || last_of_byte !== oldest_symbol.last ||
                    text_done !== oldest_symbol.done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("symbol mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                 oldest_symbol.sym, oldest_symbol.last, oldest_symbol.done,
                                 symbol, last_of_byte, text_done);
                end
            end
        end
    end

    // predictor: one input item, pushes the symbols it decodes
    task automatic predict_item(input logic o, input logic [IDX_W-1:0] ni,
                                input logic [IDX_W-1:0] li, input logic [IDX_W-1:0] ri,
                                input logic lf, input logic [SYM_W-1:0] ls,
                                input logic [BYTE_W-1:0] cb);
        htd_node_t        here;
        htd_node_t        reached;
        logic [IDX_W-1:0] child;
        decoded_t         burst [8];
        int               count;
        int               b;
        bit               stop;
        count = 0;
        stop = 0;
        decoding_items++;
        if (o == OP_NODE) begin
            code_tree[ni] = '{left: li, right: ri, leaf: lf, symbol: ls};
            if (!entry_written[ni]) begin
                entry_written[ni] = 1'b1;
                written_entries.push_back(ni);
            end
            return;
        end
        // finished text or zero length: byte is dropped
        if (text_finished || symbol_count >= sym_limit)
            return;
        for (b = BYTE_W - 1; b >= 0 && !stop; b--) begin
            here = code_tree[tree_cursor];
            child = cb[b] ? here.right : here.left;
            reached = code_tree[child];
            tree_cursor = child;
            if (reached.leaf) begin
                symbol_count = symbol_count + LEN_W'(1);
                burst[count] = '{sym: reached.symbol, last: 1'b0,
                                 done: (symbol_count == sym_limit)};
                tree_cursor = '0;
                if (burst[count].done) begin
                    text_finished = 1'b1;
                    stop = 1'b1;
                end
                count++;
            end
        end
        if (count > 0)
            burst[count - 1].last = 1'b1;
        for (b = 0; b < count; b++)
            pending_symbols.push_back(burst[b]);
    endtask

    // one item transfer on the input channel, with random gaps
    task automatic drive_item(input logic o, input logic [IDX_W-1:0] ni,
                              input logic [IDX_W-1:0] li, input logic [IDX_W-1:0] ri,
                              input logic lf, input logic [SYM_W-1:0] ls,
                              input logic [BYTE_W-1:0] cb);
        while (!steady && $urandom_range(0, 99) < 19) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        op          <= o;
        node_index  <= ni;
        left_index  <= li;
        right_index <= ri;
        is_leaf     <= lf;
        leaf_symbol <= ls;
        code_byte   <= cb;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    task automatic send_node(input logic [IDX_W-1:0] ni, input logic [IDX_W-1:0] li,
                             input logic [IDX_W-1:0] ri, input logic lf,
                             input logic [SYM_W-1:0] ls);
        logic [BYTE_W-1:0] filler;
        filler = BYTE_W'($urandom_range(0, 255));
        predict_item(OP_NODE, ni, li, ri, lf, ls, filler);
        drive_item(OP_NODE, ni, li, ri, lf, ls, filler);
    endtask

    task automatic send_code(input logic [BYTE_W-1:0] cb);
        htd_node_t filler;
        logic [IDX_W-1:0] filler_index;
        filler = htd_node_t'($urandom());
        filler_index = IDX_W'($urandom_range(0, NODES - 1));
        predict_item(OP_CODE, filler_index, filler.left, filler.right, filler.leaf,
                     filler.symbol, cb);
        drive_item(OP_CODE, filler_index, filler.left, filler.right, filler.leaf,
                   filler.symbol, cb);
    endtask

    // stop sending, wait for every expected symbol, then let the queue drain
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_sym_limit(input logic [DATA_W-1:0] word);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= SYM_LIMIT_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a new text restarts the walk, table kept
        sym_limit     = word[LEN_W-1:0];
        tree_cursor   = '0;
        symbol_count  = '0;
        text_finished = 1'b0;
    endtask

    // child pointers only ever name written entries, or the entry itself
    function automatic logic [IDX_W-1:0] pick_child(input logic [IDX_W-1:0] self_index);
        int r;
        r = int'($urandom_range(0, written_entries.size()));
        if (r == written_entries.size())
            return self_index;
        return written_entries[r];
    endfunction

    // load a random code tree bottom-up, root at entry 0 written last
    task automatic load_code_tree();
        bit               taken [NODES];
        logic [IDX_W-1:0] subtrees [$];
        int               leaves;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        int               k;
        logic [IDX_W-1:0] fresh;
        leaves = int'($urandom_range(2, 8));
        taken[0] = 1'b1;
        for (k = 0; k < 2 * leaves - 2; k++) begin
            do
                fresh = IDX_W'($urandom_range(1, NODES - 1));
            while (taken[fresh]);
            taken[fresh] = 1'b1;
            if (k < leaves) begin
                send_node(fresh, pick_child(fresh), pick_child(fresh), 1'b1,
                          SYM_W'($urandom_range(0, 255)));
                subtrees.push_back(fresh);
            end
            else begin
                a = subtrees[0];
                b = subtrees[1];
                void'(subtrees.pop_front());
                void'(subtrees.pop_front());
                if ($urandom_range(0, 1))
                    send_node(fresh, a, b, 1'b0, SYM_W'($urandom_range(0, 255)));
                else
                    send_node(fresh, b, a, 1'b0, SYM_W'($urandom_range(0, 255)));
                subtrees.insert(int'($urandom_range(0, subtrees.size())), fresh);
            end
        end
        // root's own leaf flag is don't-care
        send_node('0, subtrees[0], subtrees[1], 1'($urandom_range(0, 1)),
                  SYM_W'($urandom_range(0, 255)));
    endtask

    // empty row, every field set
    function automatic plan_row_t blank_row();
        plan_row_t row;
        row.kind        = ROW_ITEM;
        row.op          = OP_NODE;
        row.node_index  = '0;
        row.left_index  = '0;
        row.right_index = '0;
        row.is_leaf     = 1'b0;
        row.leaf_symbol = '0;
        row.code_byte   = '0;
        row.length_word = '0;
        row.check       = CHK_NONE;
        row.typed       = '0;
        return row;
    endfunction

    function automatic void plan_cfg(input logic [DATA_W-1:0] word);
        plan_row_t row;
        row = blank_row();
        row.kind = ROW_CFG;
        row.length_word = word;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_node(input logic [IDX_W-1:0] ni, input logic [IDX_W-1:0] li,
                                      input logic [IDX_W-1:0] ri, input logic lf,
                                      input logic [SYM_W-1:0] ls);
        plan_row_t row;
        row = blank_row();
        row.kind = ROW_ITEM;
        row.op = OP_NODE;
        row.node_index = ni;
        row.left_index = li;
        row.right_index = ri;
        row.is_leaf = lf;
        row.leaf_symbol = ls;
        row.check = CHK_NONE;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_code(input logic [BYTE_W-1:0] cb, input row_check_t chk,
                                      input decoded_t typed = '0);
        plan_row_t row;
        row = blank_row();
        row.kind = ROW_ITEM;
        row.op = OP_CODE;
        row.code_byte = cb;
        row.check = chk;
        row.typed = typed;
        directed_plan.push_back(row);
    endfunction

    // main stimulus
    initial
    begin
        int        n;
        int        held;
        int        phase;
        int        phase_items;
        int        pick;
        logic [LEN_W-1:0] new_length;
        plan_row_t row;

        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        item_valid   <= 1'b0;
        op           <= OP_NODE;
        node_index   <= '0;
        left_index   <= '0;
        right_index  <= '0;
        is_leaf      <= 1'b0;
        leaf_symbol  <= '0;
        code_byte    <= '0;
        result_ready <= 1'b0;
        steady        = 1'b0;
        mismatches    = 0;
        decoding_items = 0;
        tree_cursor   = '0;
        symbol_count  = '0;
        sym_limit     = '0;
        text_finished = 1'b0;

        // tree: 0 -> A, 10 -> ff, 11 -> 00; root leaf flag set but ignored
        plan_cfg(32'd0);
        plan_node(9'd1, 9'd1, 9'd1, 1'b1, 8'h41);
        plan_node(9'd511, 9'd511, 9'd511, 1'b1, 8'hff);
        plan_node(9'd3, 9'd3, 9'd3, 1'b1, 8'h00);
        plan_node(9'd4, 9'd511, 9'd3, 1'b0, 8'ha5);
        plan_node(9'd0, 9'd1, 9'd4, 1'b1, 8'h55);
        // zero length drops the byte
        plan_code(8'h5a, CHK_NONE);
        // one symbol text, stop inside the byte, then dropped
        plan_cfg(32'd1);
        plan_code(8'h00, CHK_ONE, '{sym: 8'h41, last: 1'b1, done: 1'b1});
        plan_code(8'hff, CHK_NONE);
        // longest text: full bytes of short codes, codes across byte borders
        plan_cfg(32'h7fff_ffff);
        plan_code(8'h00, CHK_MODEL);
        plan_code(8'hff, CHK_MODEL);
        plan_code(8'haa, CHK_MODEL);
        plan_code(8'h80, CHK_MODEL);
        plan_code(8'h40, CHK_MODEL);
        plan_code(8'h01, CHK_MODEL);
        plan_code(8'h7f, CHK_MODEL);
        // rewrite the node under the walk; a child pointing back at the root
        plan_node(9'd4, 9'd1, 9'd0, 1'b0, 8'h00);
        plan_code(8'h40, CHK_MODEL);
        plan_code(8'hff, CHK_MODEL);
        plan_cfg(32'd3);
        plan_code(8'h00, CHK_MODEL);
        plan_code(8'h00, CHK_NONE);
        // bit 31 of the written word is outside the register
        plan_cfg({1'b1, 31'd2});
        plan_code(8'h01, CHK_MODEL);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_sym_limit(row.length_word);
            end
            else begin
                held = pending_symbols.size();
                predict_item(row.op, row.node_index, row.left_index, row.right_index,
                             row.is_leaf, row.leaf_symbol, row.code_byte);
                if (row.check != CHK_MODEL) begin
                    while (pending_symbols.size() > held)
                        void'(pending_symbols.pop_back());
                    if (row.check == CHK_ONE)
                        pending_symbols.push_back(row.typed);
                end
                drive_item(row.op, row.node_index, row.left_index, row.right_index,
                           row.is_leaf, row.leaf_symbol, row.code_byte);
            end
        end

        // random part: a new text per phase, mostly a fresh tree, then code bytes
        phase = 0;
        while (decoding_items < TARGET_ITEMS) begin
            settle();
            steady = (phase == 1 || phase == 2);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                new_length = '0;
            else if (pick == 1)
                new_length = LEN_W'($urandom_range(1, 3));
            else if (pick == 2)
                new_length = {LEN_W{1'b1}};
            else
                new_length = LEN_W'($urandom_range(5, 60));
            write_sym_limit({1'($urandom_range(0, 1)), new_length});
            if (phase == 0 || $urandom_range(0, 3) != 0)
                load_code_tree();
            phase_items = $urandom_range(15, 40);
            for (n = 0; n < phase_items; n++) begin
                if ($urandom_range(0, 99) < 4)
                    settle();
                if ($urandom_range(0, 99) < 85)
                    send_code(BYTE_W'($urandom_range(0, 255)));
                else begin
                    pick = $urandom_range(0, NODES - 1);
                    send_node(IDX_W'(pick), pick_child(IDX_W'(pick)),
                              pick_child(IDX_W'(pick)), 1'($urandom_range(0, 1)),
                              SYM_W'($urandom_range(0, 255)));
                end
            end
            phase++;
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0 && pending_symbols.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
